### sv/substring_first_match_search_defines.svh
// Assertion macros shared by the checker of the search block.
`ifndef SUBSTRING_FIRST_MATCH_SEARCH_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSFM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ssfm_pkg.sv
package ssfm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 1048576;

  localparam int CHAR_W  = 16;
  localparam int POS_W   = 31;
  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int COUNT_W = $clog2(TEXT_MAX + 1);
  localparam int START_W = $clog2(TEXT_MAX);

  typedef enum logic [1:0] {
    MODE_PATTERN = 2'd0,
    MODE_TEXT    = 2'd1,
    MODE_FINISH  = 2'd2
  } mode_t;

  typedef struct packed {
    logic shift_text;
    logic shift_pat;
    logic clear;
  } cell_ctrl_t;

endpackage

### sv/ssfm_cell.sv
module ssfm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  ssfm_pkg::cell_ctrl_t       ctrl,
  input  logic [ssfm_pkg::CHAR_W-1:0] text_in,
  input  logic [ssfm_pkg::CHAR_W-1:0] pat_in,
  input  logic                       used_in,
  output logic [ssfm_pkg::CHAR_W-1:0] text_q,
  output logic [ssfm_pkg::CHAR_W-1:0] pat_q,
  output logic                       used_q,
  output logic                       hit
);
  import ssfm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      text_q <= '0;
      used_q <= 1'b0;
    end else begin
      if (ctrl.shift_text) begin
        text_q <= text_in;
      end
      if (ctrl.shift_pat) begin
        used_q <= used_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_pat) begin
      pat_q <= pat_in;
    end
  end

  // A cell beyond the loaded pattern never blocks a match.
  assign hit = !used_q || (text_q == pat_q);

endmodule

### sv/substring_first_match_search.sv
// A finish word's result is registered, shown in the cycle after acceptance.
// Throughput: one word per cycle when no result is stalled; the window compare
// of a text word is done in the cycle after it, alongside the next word, by a
// chain of 16 cells. Reset and a finish word clear the text window, counters
// and search flags; the pattern cells hold undefined data until loaded.
module substring_first_match_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  mode,
  input  logic [ssfm_pkg::CHAR_W-1:0] character,
  input  logic [ssfm_pkg::POS_W-1:0]  base_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [ssfm_pkg::POS_W-1:0]  position,
  output logic                        overflow
);
  import ssfm_pkg::*;

  logic [LEN_W-1:0]   pattern_length;
  logic [COUNT_W-1:0] text_count;
  logic               match_seen;
  logic [START_W-1:0] match_start;
  logic               capacity_exceeded;
  logic               pending;

  logic [CHAR_W-1:0]      text_q [PATTERN_MAX];
  logic [CHAR_W-1:0]      pat_q  [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] used_q;
  logic [PATTERN_MAX-1:0] hit;

  logic in_fire, is_pat, is_text, is_fin, pat_room, text_room;
  cell_ctrl_t ctrl;

  logic               window_ok;
  logic [START_W-1:0] start_now;
  logic               seen_eff;
  logic [START_W-1:0] start_eff;
  logic [POS_W:0]     sum;
  logic [POS_W-1:0]   sat_pos;
  logic               found_next;
  logic [POS_W-1:0]   position_next;

  assign in_stall = out_valid && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign is_pat   = in_fire && (mode == MODE_PATTERN);
  assign is_text  = in_fire && (mode == MODE_TEXT);
  assign is_fin   = in_fire && (mode == MODE_FINISH);

  assign pat_room  = pattern_length < LEN_W'(PATTERN_MAX);
  assign text_room = text_count < COUNT_W'(TEXT_MAX);

  assign ctrl.shift_pat  = is_pat && pat_room;
  assign ctrl.shift_text = is_text && text_room;
  assign ctrl.clear      = is_fin;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      ssfm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .text_in (character),
        .pat_in  (character),
        .used_in (1'b1),
        .text_q  (text_q[k]),
        .pat_q   (pat_q[k]),
        .used_q  (used_q[k]),
        .hit     (hit[k])
      );
    end else begin : g_body
      ssfm_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .ctrl    (ctrl),
        .text_in (text_q[k-1]),
        .pat_in  (pat_q[k-1]),
        .used_in (used_q[k-1]),
        .text_q  (text_q[k]),
        .pat_q   (pat_q[k]),
        .used_q  (used_q[k]),
        .hit     (hit[k])
      );
    end
  end

  assign window_ok = pending && !match_seen && (pattern_length != '0) &&
                     (text_count >= COUNT_W'(pattern_length)) && (&hit);
  assign start_now = START_W'(text_count - COUNT_W'(pattern_length));
  assign seen_eff  = match_seen || window_ok;
  assign start_eff = window_ok ? start_now : match_start;

  assign sum     = {1'b0, base_index} + (POS_W+1)'(start_eff);
  assign sat_pos = sum[POS_W] ? {POS_W{1'b1}} : sum[POS_W-1:0];

  always_comb begin
    found_next    = 1'b0;
    position_next = '0;
    if (!capacity_exceeded) begin
      if (pattern_length == '0) begin
        found_next    = 1'b1;
        position_next = base_index;
      end else if (seen_eff) begin
        found_next    = 1'b1;
        position_next = sat_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length    <= '0;
      text_count        <= '0;
      match_seen        <= 1'b0;
      match_start       <= '0;
      capacity_exceeded <= 1'b0;
      pending           <= 1'b0;
    end else if (is_fin) begin
      pattern_length    <= '0;
      text_count        <= '0;
      match_seen        <= 1'b0;
      match_start       <= '0;
      capacity_exceeded <= 1'b0;
      pending           <= 1'b0;
    end else begin
      pending <= ctrl.shift_text;
      if (window_ok) begin
        match_seen  <= 1'b1;
        match_start <= start_now;
      end
      if (ctrl.shift_pat) begin
        pattern_length <= pattern_length + LEN_W'(1);
      end
      if (ctrl.shift_text) begin
        text_count <= text_count + COUNT_W'(1);
      end
      if ((is_pat && !pat_room) || (is_text && !text_room)) begin
        capacity_exceeded <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_fin) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_fin) begin
      found    <= found_next;
      position <= position_next;
      overflow <= capacity_exceeded;
    end
  end

endmodule

### sv/ssfm_checker.sv
`include "substring_first_match_search_defines.svh"

module ssfm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  mode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        found,
  input logic [ssfm_pkg::POS_W-1:0]  position,
  input logic                        overflow
);
  import ssfm_pkg::*;

  `SSFM_ASSERT_NEXT(a_finish_gives_result, in_valid && !in_stall && (mode == MODE_FINISH), out_valid, "finish word gave no result")
  `SSFM_ASSERT_NOW(a_full_output_stalls_input, out_valid && out_stall, in_stall, "input taken while result blocked")
  `SSFM_ASSERT_NOW(a_overflow_not_found, out_valid && overflow, !found, "found set together with overflow")
  `SSFM_ASSERT_NOW(a_miss_position_zero, out_valid && !found, position == '0, "nonzero position on a miss")
  `SSFM_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid && $stable(found) && $stable(position), "stalled result changed")

endmodule

bind substring_first_match_search ssfm_checker u_ssfm_checker (.*);

### tb/sv/tb_substring_first_match_search.sv
module tb_substring_first_match_search;
  timeunit 1ns;
  timeprecision 1ps;

  import ssfm_pkg::*;

  localparam logic [1:0]       MODE_IGNORED   = 2'd3;
  localparam logic [POS_W-1:0] POS_MAX        = {POS_W{1'b1}};
  localparam int               WATCHDOG_LIMIT = 2000;
  localparam int               REPORT_LIMIT   = 10;
  localparam int               RANDOM_WORDS   = 1500;
  localparam int               SETTLE_CYCLES  = 10;
  localparam int               STALL_RUN_MAX  = 8;
  localparam bit               TYPED          = 1'b1;
  localparam bit               PREDICTED      = 1'b0;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } search_result_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  base;
    logic              typed;
    search_result_t    want;
  } stim_row_t;

  localparam search_result_t NO_CHECK = '0;

  // Typed expectations cover the empty pattern, the saturated position and a text
  // shorter than its pattern; the remaining rows go through the predictor.
  localparam stim_row_t [0:19] DIRECTED_ROWS = {
    {MODE_FINISH,  16'h0000, 31'h0000_0000, TYPED,     1'b1, 31'h0000_0000, 1'b0},
    {MODE_IGNORED, 16'hFFFF, 31'h7FFF_FFFF, PREDICTED, NO_CHECK},
    {MODE_FINISH,  16'h0000, 31'h7FFF_FFFF, TYPED,     1'b1, 31'h7FFF_FFFF, 1'b0},
    {MODE_PATTERN, 16'h0000, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_PATTERN, 16'hFFFF, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h1234, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h0000, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'hFFFF, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_FINISH,  16'h0000, 31'h7FFF_FFFF, TYPED,     1'b1, 31'h7FFF_FFFF, 1'b0},
    {MODE_PATTERN, 16'h00AB, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_PATTERN, 16'h00CD, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_PATTERN, 16'h00EF, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h00AB, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h00CD, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_FINISH,  16'hFFFF, 31'h0000_0005, TYPED,     1'b0, 31'h0000_0000, 1'b0},
    {MODE_PATTERN, 16'h5555, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h5555, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_PATTERN, 16'hAAAA, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_TEXT,    16'h5555, 31'h0000_0000, PREDICTED, NO_CHECK},
    {MODE_FINISH,  16'h0000, 31'h4000_0000, PREDICTED, NO_CHECK}
  };

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [1:0]        mode       = 2'd0;
  logic [CHAR_W-1:0] character  = '0;
  logic [POS_W-1:0]  base_index = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic              found;
  logic [POS_W-1:0]  position;
  logic              overflow;

  substring_first_match_search dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .character  (character),
    .base_index (base_index),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .position   (position),
    .overflow   (overflow)
  );

  always #4 clk = ~clk;

  logic [CHAR_W-1:0] pat_units [PATTERN_MAX];
  logic [CHAR_W-1:0] recent_text [PATTERN_MAX];
  int                pat_len   = 0;
  int                text_len  = 0;
  bit                hit       = 1'b0;
  int                hit_start = 0;
  bit                over_cap  = 1'b0;

  search_result_t result_q [$];
  int             mismatches   = 0;
  int             words_sent   = 0;
  int             burst_left   = 0;
  int             idle_cycles  = 0;
  int             stall_level  = 0;
  int             stall_span   = 0;
  int             stall_run    = 0;

  initial begin
    foreach (pat_units[k]) begin
      pat_units[k]   = '0;
      recent_text[k] = '0;
    end
  end

  function automatic void search_step(input logic [1:0] m, input logic [CHAR_W-1:0] c,
                                      input logic [POS_W-1:0] b, output bit made,
                                      output search_result_t res);
    logic [31:0] sum;
    bit          same;
    int          k;
    made = 1'b0;
    res  = '0;
    case (m)
      MODE_PATTERN: begin
        if (pat_len < PATTERN_MAX) begin
          pat_units[pat_len] = c;
          pat_len++;
        end else begin
          over_cap = 1'b1;
        end
      end
      MODE_TEXT: begin
        if (text_len >= TEXT_MAX) begin
          over_cap = 1'b1;
        end else begin
          for (k = PATTERN_MAX - 1; k > 0; k--) recent_text[k] = recent_text[k-1];
          recent_text[0] = c;
          text_len++;
          if (!hit && pat_len > 0 && text_len >= pat_len) begin
            same = 1'b1;
            for (k = 0; k < pat_len; k++) begin
              if (pat_units[k] != recent_text[pat_len-1-k]) same = 1'b0;
            end
            if (same) begin
              hit       = 1'b1;
              hit_start = text_len - pat_len;
            end
          end
        end
      end
      MODE_FINISH: begin
        made         = 1'b1;
        res.overflow = over_cap;
        if (!over_cap) begin
          if (pat_len == 0) begin
            res.found    = 1'b1;
            res.position = b;
          end else if (hit) begin
            sum          = {1'b0, b} + 32'(hit_start);
            res.found    = 1'b1;
            res.position = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
          end
        end
        for (k = 0; k < PATTERN_MAX; k++) begin
          pat_units[k]   = '0;
          recent_text[k] = '0;
        end
        pat_len   = 0;
        text_len  = 0;
        hit       = 1'b0;
        hit_start = 0;
        over_cap  = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] m, input logic [CHAR_W-1:0] c,
                           input logic [POS_W-1:0] b, input bit typed = PREDICTED,
                           input search_result_t want = NO_CHECK);
    search_result_t predicted;
    bit             made;
    int             gap;
    in_valid   <= 1'b1;
    mode       <= m;
    character  <= c;
    base_index <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    search_step(m, c, b, made, predicted);
    if (made) result_q.push_back(typed ? want : predicted);
    if (m != MODE_IGNORED) words_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [CHAR_W-1:0] any_char();
    return CHAR_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic run_random_sequence();
    logic [CHAR_W-1:0] alphabet [4];
    logic [CHAR_W-1:0] pat [20];
    logic [POS_W-1:0]  b;
    logic [CHAR_W-1:0] c;
    int                alpha_n;
    int                pat_n;
    int                text_n;
    int                plant_at;
    int                pick;
    bit                plant;
    foreach (alphabet[k]) alphabet[k] = any_char();
    alpha_n = $urandom_range(1, 4);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 12)) begin
        send_word(2'($urandom_range(0, 3)), any_char(), POS_W'($urandom));
      end
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0) pat_n = 0;
      else if (pick < 14) pat_n = $urandom_range(1, 5);
      else if (pick < 18) pat_n = $urandom_range(6, 16);
      else pat_n = $urandom_range(17, 20);
      text_n   = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(0, pat_n + 12);
      plant    = $urandom_range(0, 1) && (text_n >= pat_n);
      plant_at = plant ? $urandom_range(0, text_n - pat_n) : 0;
      for (int k = 0; k < pat_n; k++) begin
        pat[k] = ($urandom_range(0, 7) == 0) ? any_char()
                                             : alphabet[$urandom_range(0, alpha_n - 1)];
        send_word(MODE_PATTERN, pat[k], POS_W'($urandom));
      end
      for (int t = 0; t < text_n; t++) begin
        if ($urandom_range(0, 31) == 0) send_word(MODE_IGNORED, any_char(), POS_W'($urandom));
        if ($urandom_range(0, 31) == 0) send_word(MODE_PATTERN, alphabet[0], '0);
        if (plant && t >= plant_at && t < plant_at + pat_n) c = pat[t - plant_at];
        else c = alphabet[$urandom_range(0, alpha_n - 1)];
        send_word(MODE_TEXT, c, POS_W'($urandom));
      end
      pick = $urandom_range(0, 7);
      if (pick == 0) b = POS_MAX - POS_W'($urandom_range(0, 20));
      else if (pick == 1) b = '0;
      else b = POS_W'($urandom);
      if ($urandom_range(0, 9) != 0) send_word(MODE_FINISH, any_char(), b);
    end
  endtask

  task automatic log_mismatch(input string what, input search_result_t want,
                              input search_result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t %s: expected found %0b position %h overflow %0b, got found %0b position %h overflow %0b",
               $time, what, want.found, want.position, want.overflow,
               got.found, got.position, got.overflow);
    end
  endtask

  always @(posedge clk) begin : result_check
    search_result_t got;
    search_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {found, position, overflow};
      if (result_q.size() == 0) begin
        log_mismatch("unexpected result", NO_CHECK, got);
      end else begin
        want = result_q.pop_front();
        if (got.found !== want.found || got.position !== want.position ||
            got.overflow !== want.overflow) begin
          log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin : stall_pattern
    bit next_stall;
    if (rst) begin
      out_stall   <= 1'b0;
      stall_level <= 0;
      stall_span  <= 0;
      stall_run   <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_level <= $urandom_range(0, 2);
        stall_span  <= $urandom_range(16, 80);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_level)
        0: next_stall = 1'b0;
        1: next_stall = ($urandom_range(0, 3) == 0);
        default: next_stall = ($urandom_range(0, 3) != 0);
      endcase
      if (stall_run >= STALL_RUN_MAX) next_stall = 1'b0;
      out_stall <= next_stall;
      stall_run <= next_stall ? stall_run + 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** substring_first_match_search: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    stim_row_t row;
    int        target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      row = DIRECTED_ROWS[i];
      send_word(row.mode, row.ch, row.base, row.typed, row.want);
    end

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) run_random_sequence();
    send_word(MODE_FINISH, any_char(), POS_W'($urandom));
    in_valid <= 1'b0;

    while (result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("** substring_first_match_search: PASSED **");
    end else begin
      $display("** substring_first_match_search: FAILED **");
    end
    $finish;
  end

endmodule
